### rtl/zdb_pkg.sv
// zdb_pkg: shared widths, codes and command/status types for the zone distance blend block
package zdb_pkg;

  // field widths
  localparam int COORD_BITS      = 24;
  localparam int BLEND_FRAC_BITS = 15;
  localparam int RADIUS_BITS     = COORD_BITS;
  localparam int MAG_BITS        = COORD_BITS + 1;
  localparam int SUM_BITS        = 2 * MAG_BITS;
  localparam int ROOT_BITS       = MAG_BITS;
  localparam int DIST_BITS       = ROOT_BITS;
  localparam int REM_BITS        = ROOT_BITS + 2;
  localparam int BLEND_BITS      = BLEND_FRAC_BITS + 1;
  localparam int DIV_STEPS       = BLEND_FRAC_BITS + 1;

  // stream and config port widths
  localparam int IN_FIELD_BITS   = 3 * COORD_BITS;
  localparam int IN_DATA_BITS    = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS  = BLEND_BITS + DIST_BITS + 3;
  localparam int OUT_DATA_BITS   = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = COORD_BITS;

  // output field positions inside m_tdata
  localparam int OUT_DIST_LSB    = BLEND_BITS;
  localparam int OUT_ACTIVE_BIT  = BLEND_BITS + DIST_BITS;
  localparam int OUT_ENTER_BIT   = OUT_ACTIVE_BIT + 1;
  localparam int OUT_EXIT_BIT    = OUT_ACTIVE_BIT + 2;

  // step counter
  localparam int STEP_MAX        = (ROOT_BITS > DIV_STEPS) ? ROOT_BITS : DIV_STEPS;
  localparam int CNT_BITS        = $clog2(STEP_MAX);
  localparam logic [CNT_BITS-1:0] SQ_LAST   = CNT_BITS'(3);
  localparam logic [CNT_BITS-1:0] ROOT_LAST = CNT_BITS'(ROOT_BITS - 1);
  localparam logic [CNT_BITS-1:0] DIV_LAST  = CNT_BITS'(DIV_STEPS - 1);

  localparam logic [BLEND_BITS-1:0] BLEND_FULL = {1'b1, {BLEND_FRAC_BITS{1'b0}}};

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTRE_X = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTRE_Y = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTRE_Z = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_INNER    = CFG_IDX_BITS'(3);
  localparam logic [CFG_IDX_BITS-1:0] REG_OUTER    = CFG_IDX_BITS'(4);

  // axis codes for the shared squarer
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_CLASS,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic  load;
    logic  mul;
    logic  acc;
    axis_t axis;
    logic  root_step;
    logic  classify;
    logic  div_step;
    logic  emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic out_busy;
  } sts_t;

endpackage

### rtl/zdb_ctrl.sv
// zdb_ctrl: sequencer that walks one item through square, root, classify and, when needed, divide
module zdb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  zdb_pkg::sts_t sts,
  output zdb_pkg::cmd_t cmd
);
  import zdb_pkg::*;

  state_t              state, state_next;
  logic [CNT_BITS-1:0] cnt, cnt_next;

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.axis   = AXIS_X;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        // product of one axis per cycle, accumulated in the following cycle
        cmd.mul  = (cnt != SQ_LAST);
        cmd.acc  = (cnt != '0);
        cmd.axis = axis_t'(cnt[1:0]);
        if (cnt == SQ_LAST) begin
          cnt_next   = '0;
          state_next = ST_ROOT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt == ROOT_LAST) begin
          cnt_next   = '0;
          state_next = ST_CLASS;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_CLASS: begin
        cmd.classify = 1'b1;
        cnt_next     = '0;
        state_next   = sts.need_div ? ST_DIVIDE : ST_DONE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (cnt == DIV_LAST) begin
          cnt_next   = '0;
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // only one kind of datapath operation per cycle
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.mul | cmd.acc, cmd.root_step, cmd.classify,
              cmd.div_step, cmd.emit}))
    else $error("zdb_ctrl: overlapping datapath commands");

  // a result is never pushed into an occupied, stalled output register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !sts.out_busy)
    else $error("zdb_ctrl: emit into busy output");

  // an item is taken only from idle, and squaring then starts at the first step
  a_load_after_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_SQUARE) && (cnt == '0))
    else $error("zdb_ctrl: load did not start squaring");

  // the divide runs only when classification asked for it
  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(cmd.div_step) |-> $past(cmd.classify) && $past(sts.need_div))
    else $error("zdb_ctrl: divide entered without classification");

endmodule

### rtl/zdb_dp.sv
// zdb_dp: config registers, squarer, iterative square root, divider and output register
module zdb_dp (
  input  logic                                clk,
  input  logic                                rst,
  // configuration writes
  input  logic                                cfg_wr,
  input  logic [zdb_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [zdb_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // input item
  input  logic [zdb_pkg::IN_DATA_BITS-1:0]    s_tdata,
  // output item
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [zdb_pkg::OUT_DATA_BITS-1:0]   m_tdata,
  // control
  input  zdb_pkg::cmd_t                       cmd,
  output zdb_pkg::sts_t                       sts
);
  import zdb_pkg::*;

  // configuration
  logic signed [COORD_BITS-1:0]  centre_x, centre_y, centre_z;
  logic        [RADIUS_BITS-1:0] inner_radius, outer_radius;

  // latched listener position
  logic signed [COORD_BITS-1:0]  pos_x, pos_y, pos_z;

  // squarer
  logic signed [COORD_BITS-1:0]  pos_sel, centre_sel;
  logic signed [MAG_BITS-1:0]    diff;
  logic        [MAG_BITS-1:0]    mag;
  logic        [SUM_BITS-1:0]    prod;

  // square root
  logic [SUM_BITS-1:0]  rad;
  logic [REM_BITS-1:0]  root_rem;
  logic [ROOT_BITS-1:0] root;
  logic [REM_BITS-1:0]  cur, trial;
  logic                 root_ge;

  // classify and divide
  logic                   below_inner, above_outer, need_div;
  logic [RADIUS_BITS:0]   div_rem;
  logic [RADIUS_BITS-1:0] den;
  logic                   div_ge;
  logic [RADIUS_BITS:0]   div_diff;
  logic [BLEND_BITS-1:0]  blend;

  // output register
  logic                  was_active;
  logic [BLEND_BITS-1:0] out_blend;
  logic [DIST_BITS-1:0]  out_dist;
  logic                  out_active, out_entered, out_exited;
  logic                  new_active;

  // config writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x     <= '0;
      centre_y     <= '0;
      centre_z     <= '0;
      inner_radius <= '0;
      outer_radius <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_CENTRE_X: centre_x     <= cfg_data[COORD_BITS-1:0];
        REG_CENTRE_Y: centre_y     <= cfg_data[COORD_BITS-1:0];
        REG_CENTRE_Z: centre_z     <= cfg_data[COORD_BITS-1:0];
        REG_INNER:    inner_radius <= cfg_data[RADIUS_BITS-1:0];
        REG_OUTER:    outer_radius <= cfg_data[RADIUS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // axis select and magnitude of the difference
  always_comb begin
    unique case (cmd.axis)
      AXIS_X: begin
        pos_sel    = pos_x;
        centre_sel = centre_x;
      end
      AXIS_Y: begin
        pos_sel    = pos_y;
        centre_sel = centre_y;
      end
      AXIS_Z: begin
        pos_sel    = pos_z;
        centre_sel = centre_z;
      end
      default: begin
        pos_sel    = pos_x;
        centre_sel = centre_x;
      end
    endcase
    diff = {pos_sel[COORD_BITS-1], pos_sel} - {centre_sel[COORD_BITS-1], centre_sel};
    mag  = diff[MAG_BITS-1] ? MAG_BITS'(-diff) : MAG_BITS'(diff);
  end

  // one restoring root step: two radicand bits in, one root bit out
  always_comb begin
    cur     = {root_rem[REM_BITS-3:0], rad[SUM_BITS-1 -: 2]};
    trial   = {root, 2'b01};
    root_ge = (cur >= trial);
  end

  // classification of the distance against the radii
  always_comb begin
    below_inner = (root < {1'b0, inner_radius});
    above_outer = (root > {1'b0, outer_radius});
    need_div    = !below_inner && !above_outer && (outer_radius != inner_radius);
  end

  // one restoring divide step
  always_comb begin
    div_ge   = (div_rem >= {1'b0, den});
    div_diff = div_ge ? (div_rem - {1'b0, den}) : div_rem;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_x    <= s_tdata[COORD_BITS-1:0];
      pos_y    <= s_tdata[2*COORD_BITS-1:COORD_BITS];
      pos_z    <= s_tdata[3*COORD_BITS-1:2*COORD_BITS];
      rad      <= '0;
      root_rem <= '0;
      root     <= '0;
    end
    if (cmd.mul) begin
      prod <= mag * mag;
    end
    if (cmd.acc) begin
      rad <= rad + prod;
    end
    if (cmd.root_step) begin
      root_rem <= root_ge ? (cur - trial) : cur;
      root     <= {root[ROOT_BITS-2:0], root_ge};
      rad      <= {rad[SUM_BITS-3:0], 2'b00};
    end
    if (cmd.classify) begin
      div_rem <= {1'b0, outer_radius - root[RADIUS_BITS-1:0]};
      den     <= outer_radius - inner_radius;
      if (below_inner) begin
        blend <= BLEND_FULL;
      end else if (above_outer) begin
        blend <= '0;
      end else if (outer_radius == inner_radius) begin
        blend <= BLEND_FULL;
      end else begin
        blend <= '0;
      end
    end
    if (cmd.div_step) begin
      blend   <= {blend[BLEND_BITS-2:0], div_ge};
      div_rem <= {div_diff[RADIUS_BITS-1:0], 1'b0};
    end
  end

  assign new_active = (blend != '0);

  // output register and zone state
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      was_active <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid   <= 1'b1;
      was_active <= new_active;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_blend   <= blend;
      out_dist    <= root;
      out_active  <= new_active;
      out_entered <= new_active && !was_active;
      out_exited  <= !new_active && was_active;
    end
  end

  // pack result fields, lowest first
  always_comb begin
    m_tdata = '0;
    m_tdata[BLEND_BITS-1:0]                 = out_blend;
    m_tdata[OUT_DIST_LSB +: DIST_BITS]      = out_dist;
    m_tdata[OUT_ACTIVE_BIT]                 = out_active;
    m_tdata[OUT_ENTER_BIT]                  = out_entered;
    m_tdata[OUT_EXIT_BIT]                   = out_exited;
  end

  assign sts.need_div = need_div;
  assign sts.out_busy = m_tvalid && !m_tready;

  // blend never exceeds full scale
  a_blend_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_blend <= BLEND_FULL))
    else $error("zdb_dp: blend above full scale");

  // active flag agrees with the blend value
  a_active_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_active == (out_blend != '0)))
    else $error("zdb_dp: active flag disagrees with blend");

  // entry and exit never flagged together
  a_enter_exit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_entered && out_exited))
    else $error("zdb_dp: entered and exited both set");

  // zone state follows the emitted active flag
  a_state_track: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (was_active == out_active))
    else $error("zdb_dp: zone state out of step with output");

endmodule

### rtl/zone_distance_blend_top.sv
// zone_distance_blend_top: listener-to-zone distance and blend factor, top level
//
//  channel  signals                                   fields (lowest bit first)
//  -------  ----------------------------------------  ------------------------------------
//  s        s_tvalid s_tready s_tdata[71:0]           listener_x, listener_y, listener_z
//  m        m_tvalid m_tready m_tdata[47:0]           blend, distance, active, entered,
//                                                     exited, zero fill
//  cfg      cfg_valid cfg_ready cfg_index cfg_data    0 centre_x, 1 centre_y, 2 centre_z,
//                                                     3 inner_radius, 4 outer_radius
//
// An item goes from acceptance back to ready through accept, square/accumulate, root,
// classify, the falloff divide when it runs, and emit; the one-bit-per-cycle square
// root and divider are the longest of these steps.
// Reset is synchronous on rst and clears the config registers and the zone state.
// A finished item waits in the output register while the next one is computed; the
// sequencer holds only if that register is still occupied when the next item is done.
// cfg_ready is always high; writes must go in only while no item is in flight, which the block does not enforce.
module zone_distance_blend_top (
  input  logic                               clk,
  input  logic                               rst,
  // listener_x, listener_y, listener_z
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [zdb_pkg::IN_DATA_BITS-1:0]   s_tdata,
  // blend, distance, active, entered, exited, zero fill
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [zdb_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [zdb_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [zdb_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import zdb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  // sequencer
  zdb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and output register
  zdb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### tb/sv/zdb_blend_checker.sv
// zdb_blend_checker: watches the zone blend channels, predicts each result item and compares
`timescale 1ns / 100ps

module zdb_blend_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [zdb_pkg::IN_DATA_BITS-1:0]  s_tdata,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [zdb_pkg::OUT_DATA_BITS-1:0] m_tdata,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [zdb_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [zdb_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output int                                fail_count,
  output int                                blends_waiting,
  output int                                blends_checked,
  output int                                full_seen,
  output int                                falloff_seen
);

  localparam int CW          = zdb_pkg::COORD_BITS;
  localparam int RW          = zdb_pkg::RADIUS_BITS;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [zdb_pkg::BLEND_BITS-1:0] blend;
    logic [zdb_pkg::DIST_BITS-1:0]  distance;
    logic                           active;
    logic                           entered;
    logic                           exited;
  } zone_blend_t;

  // shadow copy of the zone registers and the one-bit zone state
  logic [CW-1:0] zone_cx;
  logic [CW-1:0] zone_cy;
  logic [CW-1:0] zone_cz;
  logic [RW-1:0] inner_r;
  logic [RW-1:0] outer_r;
  logic          was_in_zone;
  zone_blend_t   blend_queue[$];
  int            reports;

  // squared difference on one axis, both sides taken as two's complement
  function automatic longint unsigned axis_sq(logic [CW-1:0] pos, logic [CW-1:0] centre);
    longint delta;
    delta = longint'($signed(pos)) - longint'($signed(centre));
    return longint'(delta * delta);
  endfunction

  // largest root whose square does not exceed n, built one bit at a time
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 26; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // full inside, zero outside, truncated linear falloff between the radii
  function automatic longint unsigned falloff_blend(longint unsigned d);
    longint unsigned full;
    longint unsigned span;
    longint unsigned gap;
    full = 64'd1 << zdb_pkg::BLEND_FRAC_BITS;
    if (d < inner_r) return full;
    if (d > outer_r) return 0;
    // equal radii at the distance: zero over zero, taken as full
    if (outer_r == inner_r) return full;
    span = longint'(outer_r) - longint'(inner_r);
    gap  = longint'(outer_r) - d;
    return (gap << zdb_pkg::BLEND_FRAC_BITS) / span;
  endfunction

  function automatic zone_blend_t predict_blend(logic [zdb_pkg::IN_DATA_BITS-1:0] pos);
    zone_blend_t     r;
    longint unsigned sum;
    longint unsigned d;
    longint unsigned b;
    sum = axis_sq(pos[CW-1:0], zone_cx) + axis_sq(pos[2*CW-1:CW], zone_cy)
        + axis_sq(pos[3*CW-1:2*CW], zone_cz);
    d = floor_root(sum);
    b = falloff_blend(d);
    r.blend    = b[zdb_pkg::BLEND_BITS-1:0];
    r.distance = d[zdb_pkg::DIST_BITS-1:0];
    r.active   = (b != 0);
    r.entered  = !was_in_zone && r.active;
    r.exited   = was_in_zone && !r.active;
    return r;
  endfunction

  always @(posedge clk) begin : watch_channels
    zone_blend_t want;
    zone_blend_t got;
    if (rst) begin
      zone_cx     = '0;
      zone_cy     = '0;
      zone_cz     = '0;
      inner_r     = '0;
      outer_r     = '0;
      was_in_zone = 1'b0;
      blend_queue.delete();
      fail_count     = 0;
      blends_waiting = 0;
      blends_checked = 0;
      full_seen      = 0;
      falloff_seen   = 0;
      reports        = 0;
    end else begin
      // result item against the oldest prediction
      if (m_tvalid && m_tready) begin
        got.blend    = m_tdata[zdb_pkg::BLEND_BITS-1:0];
        got.distance = m_tdata[zdb_pkg::OUT_DIST_LSB +: zdb_pkg::DIST_BITS];
        got.active   = m_tdata[zdb_pkg::OUT_ACTIVE_BIT];
        got.entered  = m_tdata[zdb_pkg::OUT_ENTER_BIT];
        got.exited   = m_tdata[zdb_pkg::OUT_EXIT_BIT];
        if (blend_queue.size() == 0) begin
          fail_count++;
          reports++;
          if (reports <= MAX_REPORTS)
            $display("%0t: result item with no position pending: blend %0d distance %0d",
                     $realtime, got.blend, got.distance);
        end else begin
          want = blend_queue.pop_front();
          blends_checked++;
          if (want.blend == zdb_pkg::BLEND_FULL) full_seen++;
          else if (want.active) falloff_seen++;
          if (got !== want) begin
            fail_count++;
            reports++;
            if (reports <= MAX_REPORTS) begin
              $display("%0t: result %0d mismatch: expected blend %0d dist %0d act %0b ent %0b exit %0b",
                       $realtime, blends_checked, want.blend, want.distance, want.active,
                       want.entered, want.exited);
              $display("    got blend %0d dist %0d act %0b ent %0b exit %0b",
                       got.blend, got.distance, got.active, got.entered, got.exited);
            end
          end
        end
      end
      // register writes; spare indexes are ignored
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          zdb_pkg::REG_CENTRE_X: zone_cx = cfg_data;
          zdb_pkg::REG_CENTRE_Y: zone_cy = cfg_data;
          zdb_pkg::REG_CENTRE_Z: zone_cz = cfg_data;
          zdb_pkg::REG_INNER:    inner_r = cfg_data;
          zdb_pkg::REG_OUTER:    outer_r = cfg_data;
          default: ;
        endcase
      end
      // accepted position
      if (s_tvalid && s_tready) begin
        want = predict_blend(s_tdata);
        blend_queue.push_back(want);
        was_in_zone = want.active;
      end
      blends_waiting = blend_queue.size();
    end
  end

endmodule

### tb/sv/tb_zone_distance_blend_top.sv
// tb_zone_distance_blend_top: stimulus, clocking and verdict for the zone distance blend block
`timescale 1ns / 100ps

module tb_zone_distance_blend_top;

  localparam int CW              = zdb_pkg::COORD_BITS;
  localparam int RW              = zdb_pkg::RADIUS_BITS;
  localparam int IDLE_MAX        = 6;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 100;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 100;

  localparam logic [CW-1:0] COORD_MAX  = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] COORD_MIN  = {1'b1, {(CW-1){1'b0}}};
  localparam logic [RW-1:0] RADIUS_MAX = '1;

  logic                              clk;
  logic                              rst;
  logic                              s_tvalid;
  logic                              s_tready;
  logic [zdb_pkg::IN_DATA_BITS-1:0]  s_tdata;
  logic                              m_tvalid;
  logic                              m_tready;
  logic [zdb_pkg::OUT_DATA_BITS-1:0] m_tdata;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [zdb_pkg::CFG_IDX_BITS-1:0]  cfg_index;
  logic [zdb_pkg::CFG_DATA_BITS-1:0] cfg_data;

  int fail_count;
  int blends_waiting;
  int blends_checked;
  int full_seen;
  int falloff_seen;

  // stimulus bookkeeping
  bit            no_idle;
  int            positions_sent;
  int            settings_count;
  int            idle_cycles;
  logic [CW-1:0] cur_cx;
  logic [CW-1:0] cur_cy;
  logic [CW-1:0] cur_cz;

  zone_distance_blend_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  zdb_blend_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .blends_waiting (blends_waiting),
    .blends_checked (blends_checked),
    .full_seen      (full_seen),
    .falloff_seen   (falloff_seen)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, IDLE_MAX);
  endfunction

  // result side: random stall before each item
  initial begin : result_sink
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // one position item; called and returns just after a falling edge
  task automatic send_position(input logic [CW-1:0] px, input logic [CW-1:0] py,
                               input logic [CW-1:0] pz);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {pz, py, px};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    positions_sent++;
  endtask

  // position offset from the current centre along one axis
  task automatic send_on_axis(input zdb_pkg::axis_t axis, input longint off);
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [CW-1:0] pz;
    px = cur_cx;
    py = cur_cy;
    pz = cur_cz;
    case (axis)
      zdb_pkg::AXIS_X: px = CW'(longint'($signed(cur_cx)) + off);
      zdb_pkg::AXIS_Y: py = CW'(longint'($signed(cur_cy)) + off);
      default:         pz = CW'(longint'($signed(cur_cz)) + off);
    endcase
    send_position(px, py, pz);
  endtask

  task automatic write_reg(input logic [zdb_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [zdb_pkg::CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // stop sending and wait for every predicted result item
  task automatic drain_blends();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (blends_waiting != 0);
  endtask

  task automatic set_zone(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                          input logic [CW-1:0] cz, input logic [RW-1:0] inner,
                          input logic [RW-1:0] outer);
    drain_blends();
    write_reg(zdb_pkg::REG_CENTRE_X, cx);
    write_reg(zdb_pkg::REG_CENTRE_Y, cy);
    write_reg(zdb_pkg::REG_CENTRE_Z, cz);
    write_reg(zdb_pkg::REG_INNER, inner);
    write_reg(zdb_pkg::REG_OUTER, outer);
    cur_cx = cx;
    cur_cy = cy;
    cur_cz = cz;
    settings_count++;
  endtask

  initial begin : stimulus
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic [CW-1:0] cz;
    logic [RW-1:0] inner;
    logic [RW-1:0] outer;
    logic [zdb_pkg::CFG_IDX_BITS-1:0] spare_idx;
    longint far_r;
    int     span;
    longint base;
    int     pick;

    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    no_idle        = 1'b0;
    positions_sent = 0;
    settings_count = 1;
    cur_cx         = '0;
    cur_cy         = '0;
    cur_cz         = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // reset settings: both radii zero, so the centre itself hits equal radii
    send_position('0, '0, '0);
    send_on_axis(zdb_pkg::AXIS_X, 1);
    send_position(COORD_MIN, COORD_MIN, COORD_MIN);
    send_position(COORD_MAX, COORD_MAX, COORD_MAX);

    // centre at coordinate extremes, widest outer radius, falloff edges
    set_zone(COORD_MAX, COORD_MIN, '0, 24'd100, RADIUS_MAX);
    send_on_axis(zdb_pkg::AXIS_X, 0);
    send_on_axis(zdb_pkg::AXIS_X, -99);
    send_on_axis(zdb_pkg::AXIS_X, -100);
    send_on_axis(zdb_pkg::AXIS_X, -101);
    // one short of outer: blend truncates to zero and counts as an exit
    send_on_axis(zdb_pkg::AXIS_X, -(longint'(RADIUS_MAX) - 1));
    send_on_axis(zdb_pkg::AXIS_X, -longint'(RADIUS_MAX));
    send_on_axis(zdb_pkg::AXIS_X, -101);
    send_position(COORD_MIN, COORD_MAX, COORD_MIN);

    // equal radii
    set_zone('0, '0, '0, 24'd5000, 24'd5000);
    send_on_axis(zdb_pkg::AXIS_Y, 4999);
    send_on_axis(zdb_pkg::AXIS_Y, 5000);
    send_on_axis(zdb_pkg::AXIS_Y, 5001);
    send_on_axis(zdb_pkg::AXIS_Z, -5000);

    // inner above outer, then writes to the unused indexes
    set_zone(COORD_MIN, COORD_MAX, COORD_MIN, 24'd3000, 24'd1000);
    send_on_axis(zdb_pkg::AXIS_Z, 500);
    send_on_axis(zdb_pkg::AXIS_Z, 1000);
    send_on_axis(zdb_pkg::AXIS_Z, 3000);
    send_on_axis(zdb_pkg::AXIS_Z, 2999);
    drain_blends();
    for (int i = zdb_pkg::REG_OUTER + 1; i < (1 << zdb_pkg::CFG_IDX_BITS); i++)
      write_reg(zdb_pkg::CFG_IDX_BITS'(i), zdb_pkg::CFG_DATA_BITS'($urandom));
    send_on_axis(zdb_pkg::AXIS_X, 3001);

    // random settings, mostly positions around the zone
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      cx = CW'($urandom);
      cy = CW'($urandom);
      cz = CW'($urandom);
      outer = RW'($urandom_range(0, (1 << $urandom_range(3, RW)) - 1));
      inner = RW'($urandom_range(0, outer));
      if (ph == 0) begin
        inner = '0;
        outer = RADIUS_MAX;
      end else if (ph == 1) begin
        inner = outer;
      end else if (ph == 2) begin
        inner = RW'(longint'(outer) + $urandom_range(1, 5000));
      end
      if (ph == 5) begin
        cx = COORD_MAX;
        cy = COORD_MIN;
        cz = COORD_MAX;
      end
      set_zone(cx, cy, cz, inner, outer);
      if ($urandom_range(0, 1)) begin
        spare_idx = zdb_pkg::CFG_IDX_BITS'(zdb_pkg::REG_OUTER + $urandom_range(1, 3));
        write_reg(spare_idx, zdb_pkg::CFG_DATA_BITS'($urandom));
      end
      no_idle = (ph == 3) || (ph == 6);
      far_r = longint'((inner > outer) ? inner : outer);
      span  = int'((far_r + far_r / 4 + 8) * 3 / 5 + 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_position(
            CW'(longint'($signed(cur_cx)) + longint'($urandom_range(0, 2 * span)) - span),
            CW'(longint'($signed(cur_cy)) + longint'($urandom_range(0, 2 * span)) - span),
            CW'(longint'($signed(cur_cz)) + longint'($urandom_range(0, 2 * span)) - span));
        end else if (pick < 85) begin
          // on an axis at or next to one of the radii
          case ($urandom_range(0, 5))
            0:       base = longint'(inner) - 1;
            1:       base = longint'(inner);
            2:       base = longint'(inner) + 1;
            3:       base = longint'(outer) - 1;
            4:       base = longint'(outer);
            default: base = longint'(outer) + 1;
          endcase
          if ($urandom_range(0, 1)) base = -base;
          send_on_axis(zdb_pkg::axis_t'($urandom_range(0, 2)), base);
        end else begin
          send_position(CW'($urandom), CW'($urandom), CW'($urandom));
        end
      end
      no_idle = 1'b0;
    end

    drain_blends();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d listener positions over %0d zone settings, %0d results checked",
             positions_sent, settings_count, blends_checked);
    $display("blends: %0d full, %0d in falloff, %0d zero",
             full_seen, falloff_seen, blends_checked - full_seen - falloff_seen);
    if (fail_count == 0 && blends_waiting == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d failures, %0d results missing", fail_count, blends_waiting);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
